[design/fcsg_pkg.sv]
// ----------------------------------------------------------------------------
// Filled circle span generator package
// Shared widths, the command and span phase codes and the structs between the
// sequencer and the span arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fcsg_pkg;

  // Fixed field widths.
  localparam int CENTER_W = 15;
  localparam int COORD_W  = 16;
  localparam int COLOR_W  = 24;
  localparam int RAD_IN_W = 10;

  // Offsets travel sign-extended to this width, enough for the widest radius.
  localparam int OFS_W = 17;

  // Internal sum width: one bit of headroom over centre plus offset.
  localparam int SUM_W = 18;

  // Input command: start a new circle or run its next iteration.
  typedef enum logic {
    CMD_BEGIN    = 1'b0,
    CMD_CONTINUE = 1'b1
  } circle_cmd_t;

  // Which of the four mirrored spans of an iteration is being produced.
  typedef enum logic [1:0] {
    PH_LOW_OUTER  = 2'd0,
    PH_LOW_INNER  = 2'd1,
    PH_HIGH_INNER = 2'd2,
    PH_HIGH_OUTER = 2'd3
  } span_phase_t;

  // Request to the span unit.
  typedef struct packed {
    span_phase_t                 phase;
    logic signed [CENTER_W-1:0]  cx;
    logic signed [CENTER_W-1:0]  cy;
    logic signed [OFS_W-1:0]     ox;
    logic signed [OFS_W-1:0]     oy;
  } span_req_t;

  // Span coordinates produced by the span unit.
  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] xl;
    logic signed [COORD_W-1:0] xr;
  } span_t;

endpackage

`default_nettype wire

[design/filled_circle_span_generator.sv]
// The first span beat of an item goes from the input through the state register to the output register.
// A begin or continue item yields four beats, one a cycle while the output is not stalled, and the
// input is held off until the last is loaded; a continue while idle yields one empty beat.
// The sequencer walks the four span phases through one shared span adder unit.
// Reset is synchronous: it idles the sequencer, clears the active flag and the output valid.
// ----------------------------------------------------------------------------
// Filled circle span generator
// Rasterises a filled circle into horizontal spans with Andres' integer circle
// algorithm, four mirrored spans per iteration.
// ----------------------------------------------------------------------------
`default_nettype none

module filled_circle_span_generator #(
  parameter int RADIUS_BITS = 10
) (
  input  wire                                      clk,
  input  wire                                      rst_n,

  input  wire                                      in_valid,
  output logic                                     in_stall,
  input  wire                                      in_cmd,
  input  wire signed [fcsg_pkg::CENTER_W-1:0]      in_center_x,
  input  wire signed [fcsg_pkg::CENTER_W-1:0]      in_center_y,
  input  wire        [fcsg_pkg::RAD_IN_W-1:0]      in_radius,
  input  wire        [fcsg_pkg::COLOR_W-1:0]       in_color,

  output logic                                     out_valid,
  input  wire                                      out_stall,
  output logic                                     out_span_valid,
  output logic signed [fcsg_pkg::COORD_W-1:0]      out_span_y,
  output logic signed [fcsg_pkg::COORD_W-1:0]      out_span_x_left,
  output logic signed [fcsg_pkg::COORD_W-1:0]      out_span_x_right,
  output logic        [fcsg_pkg::COLOR_W-1:0]      out_span_color,
  output logic                                     out_last_of_item,
  output logic                                     out_circle_done
);
  import fcsg_pkg::*;

  // Offsets and decision widths follow the radius width.
  localparam int SW = RADIUS_BITS + 2;
  localparam int DW = RADIUS_BITS + 4;
  localparam int RAD_EXT_W = RAD_IN_W + 15;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPAN,
    ST_EMPTY
  } state_t;

  // Sequencer and circle state.
  state_t                       st_r, st_nxt;
  span_phase_t                  phase_r, phase_nxt;
  logic                         active_r, active_nxt;
  logic signed [CENTER_W-1:0]   cx_r, cx_nxt;
  logic signed [CENTER_W-1:0]   cy_r, cy_nxt;
  logic        [RADIUS_BITS-1:0] rad_r, rad_nxt;
  logic        [COLOR_W-1:0]    col_r, col_nxt;
  logic signed [SW-1:0]         ox_r, ox_nxt;
  logic signed [SW-1:0]         oy_r, oy_nxt;
  logic signed [DW-1:0]         d_r, d_nxt;

  // Output register.
  logic                         ov_r, ov_nxt;
  logic                         osv_r, osv_nxt;
  span_t                        ospan_r, ospan_nxt;
  logic        [COLOR_W-1:0]    ocol_r, ocol_nxt;
  logic                         olast_r, olast_nxt;
  logic                         odone_r, odone_nxt;

  // Helpers.
  logic                         in_acc;
  logic                         out_free;
  logic        [RAD_EXT_W-1:0]  rad_ext;
  logic        [RADIUS_BITS-1:0] rad_load;
  span_req_t                    req;
  span_t                        span;

  logic signed [DW-1:0]         ox_d;
  logic signed [DW-1:0]         oy_d;
  logic signed [DW-1:0]         rad_d;
  logic signed [DW-1:0]         two_ox;
  logic signed [DW-1:0]         two_gap;
  logic signed [DW-1:0]         d_a;
  logic signed [DW-1:0]         d_b;
  logic signed [DW-1:0]         d_c;
  logic signed [DW-1:0]         d_step;
  logic signed [SW-1:0]         ox_step;
  logic signed [SW-1:0]         oy_step;
  logic                         done_c;

  assign in_stall = (st_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !ov_r || !out_stall;

  // Radius masked to the configured width.
  assign rad_ext  = {15'b0, in_radius};
  assign rad_load = rad_ext[RADIUS_BITS-1:0];

  // Shared span arithmetic.
  always_comb begin
    req.phase = phase_r;
    req.cx    = cx_r;
    req.cy    = cy_r;
    req.ox    = OFS_W'(ox_r);
    req.oy    = OFS_W'(oy_r);
  end

  fcsg_span_unit u_span (
    .req  (req),
    .span (span)
  );

  // Andres decision step for the end of the iteration.
  always_comb begin
    ox_d    = DW'(ox_r);
    oy_d    = DW'(oy_r);
    rad_d   = DW'($signed({1'b0, rad_r}));
    two_ox  = ox_d <<< 1;
    two_gap = (rad_d - oy_d) <<< 1;
    d_a     = d_r - two_ox - DW'(1);
    d_b     = d_r + (oy_d <<< 1) - DW'(1);
    d_c     = d_r + ((oy_d - ox_d - DW'(1)) <<< 1);
    priority if (d_r >= two_ox) begin
      d_step  = d_a;
      ox_step = ox_r + SW'(1);
      oy_step = oy_r;
    end else if (d_r < two_gap) begin
      d_step  = d_b;
      ox_step = ox_r;
      oy_step = oy_r - SW'(1);
    end else begin
      d_step  = d_c;
      ox_step = ox_r + SW'(1);
      oy_step = oy_r - SW'(1);
    end
    done_c = oy_step < ox_step;
  end

  // Sequencer next state.
  always_comb begin
    st_nxt     = st_r;
    phase_nxt  = phase_r;
    active_nxt = active_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    rad_nxt    = rad_r;
    col_nxt    = col_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    d_nxt      = d_r;
    ov_nxt     = ov_r && out_stall;
    osv_nxt    = osv_r;
    ospan_nxt  = ospan_r;
    ocol_nxt   = ocol_r;
    olast_nxt  = olast_r;
    odone_nxt  = odone_r;

    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          phase_nxt = PH_LOW_OUTER;
          if (in_cmd == CMD_BEGIN) begin
            cx_nxt     = in_center_x;
            cy_nxt     = in_center_y;
            rad_nxt    = rad_load;
            col_nxt    = in_color;
            ox_nxt     = '0;
            oy_nxt     = SW'($signed({1'b0, rad_load}));
            d_nxt      = DW'($signed({1'b0, rad_load})) - DW'(1);
            active_nxt = 1'b1;
            st_nxt     = ST_SPAN;
          end else if (active_r) begin
            st_nxt = ST_SPAN;
          end else begin
            st_nxt = ST_EMPTY;
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          osv_nxt   = 1'b0;
          ospan_nxt = '0;
          ocol_nxt  = '0;
          olast_nxt = 1'b1;
          odone_nxt = 1'b0;
          st_nxt    = ST_IDLE;
        end
      end
      ST_SPAN: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          osv_nxt   = 1'b1;
          ospan_nxt = span;
          ocol_nxt  = col_r;
          olast_nxt = (phase_r == PH_HIGH_OUTER);
          odone_nxt = (phase_r == PH_HIGH_OUTER) && done_c;
          phase_nxt = span_phase_t'(phase_r + 2'd1);
          if (phase_r == PH_HIGH_OUTER) begin
            st_nxt = ST_IDLE;
            if (done_c) begin
              active_nxt = 1'b0;
              ox_nxt     = '0;
              oy_nxt     = '0;
              d_nxt      = '0;
            end else begin
              ox_nxt = ox_step;
              oy_nxt = oy_step;
              d_nxt  = d_step;
            end
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      phase_r  <= PH_LOW_OUTER;
      active_r <= 1'b0;
      ox_r     <= '0;
      oy_r     <= '0;
      d_r      <= '0;
      ov_r     <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      phase_r  <= phase_nxt;
      active_r <= active_nxt;
      ox_r     <= ox_nxt;
      oy_r     <= oy_nxt;
      d_r      <= d_nxt;
      ov_r     <= ov_nxt;
    end
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    rad_r   <= rad_nxt;
    col_r   <= col_nxt;
    osv_r   <= osv_nxt;
    ospan_r <= ospan_nxt;
    ocol_r  <= ocol_nxt;
    olast_r <= olast_nxt;
    odone_r <= odone_nxt;
  end

  assign out_valid        = ov_r;
  assign out_span_valid   = osv_r;
  assign out_span_y       = ospan_r.y;
  assign out_span_x_left  = ospan_r.xl;
  assign out_span_x_right = ospan_r.xr;
  assign out_span_color   = ocol_r;
  assign out_last_of_item = olast_r;
  assign out_circle_done  = odone_r;

  // An accepted item holds off the next input item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held off after an accepted beat");

  // The circle only finishes on the last beat of an item.
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_circle_done |-> out_last_of_item && out_span_valid)
    else $error("circle done outside the last span beat");

  // An empty beat always closes its item.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_span_valid |-> out_last_of_item && !out_circle_done)
    else $error("empty beat not marked last");

  // The circle state is idle after the closing beat is loaded.
  a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_circle_done) && out_valid |-> !active_r)
    else $error("circle still active after its final span");

endmodule

`default_nettype wire

[design/fcsg_span_unit.sv]
// ----------------------------------------------------------------------------
// Span arithmetic unit
// One row adder and one pair of column adders, reused for each of the four
// mirrored spans of an iteration under control of the phase code.
// ----------------------------------------------------------------------------
`default_nettype none

module fcsg_span_unit (
  input  fcsg_pkg::span_req_t req,
  output fcsg_pkg::span_t     span
);
  import fcsg_pkg::*;

  logic              outer;
  logic              below;
  logic signed [SUM_W-1:0] cx_e;
  logic signed [SUM_W-1:0] cy_e;
  logic signed [SUM_W-1:0] dy;
  logic signed [SUM_W-1:0] dx;
  logic signed [SUM_W-1:0] y_sum;
  logic signed [SUM_W-1:0] xl_sum;
  logic signed [SUM_W-1:0] xr_sum;

  // Outer spans take the horizontal offset as row distance; inner ones the vertical.
  always_comb begin
    outer = (req.phase == PH_LOW_OUTER) || (req.phase == PH_HIGH_OUTER);
    below = (req.phase == PH_LOW_OUTER) || (req.phase == PH_LOW_INNER);
    cx_e  = SUM_W'(req.cx);
    cy_e  = SUM_W'(req.cy);
    dy    = outer ? SUM_W'(req.ox) : SUM_W'(req.oy);
    dx    = outer ? SUM_W'(req.oy) : SUM_W'(req.ox);
  end

  // The shared adders.
  always_comb begin
    y_sum  = below ? (cy_e + dy) : (cy_e - dy);
    xl_sum = cx_e - dx;
    xr_sum = cx_e + dx;
    span.y  = y_sum[COORD_W-1:0];
    span.xl = xl_sum[COORD_W-1:0];
    span.xr = xr_sum[COORD_W-1:0];
  end

endmodule

`default_nettype wire
